// ----- design/fttbl_pkg.sv -----
package fttbl_pkg;

   localparam int unsigned FUNC_W   = 2;
   localparam int unsigned ADDR_W   = 32;
   localparam int unsigned PORT_W   = 16;
   localparam int unsigned PROTO_W  = 8;
   localparam int unsigned BUDGET_W = 32;
   localparam int unsigned OWNER_W  = 8;
   localparam int unsigned STATUS_W = 3;

   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CREATE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_CREATED   = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_EXISTED   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;

   typedef struct packed {
      logic [ADDR_W-1:0]  source_address;
      logic [ADDR_W-1:0]  destination_address;
      logic [PORT_W-1:0]  source_port;
      logic [PORT_W-1:0]  destination_port;
      logic [PROTO_W-1:0] protocol_number;
   } key_type;

   typedef struct packed {
      logic                recording;
      logic [BUDGET_W-1:0] budget;
      logic [OWNER_W-1:0]  owner;
   } attr_type;

   typedef struct packed {
      logic     valid;
      key_type  key;
      attr_type attr;
   } entry_type;

   function automatic logic [ADDR_W-1:0] key_hash(input key_type k);
      logic [ADDR_W-1:0] h;
      h = k.source_address ^ k.destination_address
         ^ {k.source_port, k.destination_port}
         ^ {{(ADDR_W-PROTO_W){1'b0}}, k.protocol_number};
      return h;
   endfunction

endpackage

// ----- design/fttbl_if.sv -----
interface fttbl_req_if import fttbl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [ADDR_W-1:0]   source_address;
   logic [ADDR_W-1:0]   destination_address;
   logic [PORT_W-1:0]   source_port;
   logic [PORT_W-1:0]   destination_port;
   logic [PROTO_W-1:0]  protocol_number;
   logic                new_recording;
   logic [BUDGET_W-1:0] new_budget;
   logic [OWNER_W-1:0]  new_owner;

   modport source (
      output valid, func, source_address, destination_address, source_port,
             destination_port, protocol_number, new_recording, new_budget, new_owner,
      input  ready
   );

   modport sink (
      input  valid, func, source_address, destination_address, source_port,
             destination_port, protocol_number, new_recording, new_budget, new_owner,
      output ready
   );
endinterface

interface fttbl_rsp_if import fttbl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                found_recording;
   logic [BUDGET_W-1:0] found_budget;
   logic [OWNER_W-1:0]  found_owner;

   modport source (
      output valid, status, found_recording, found_budget, found_owner,
      input  ready
   );

   modport sink (
      input  valid, status, found_recording, found_budget, found_owner,
      output ready
   );
endinterface

// ----- design/five_tuple_flow_table_core.sv -----
// five-tuple flow table: hashed buckets of WAYS entries each
// req_ch carries one transaction per flow operation (lookup, create, delete)
// with the flow key and the attributes to store on create; rsp_ch returns one
// transaction per request with a status and the attributes of the entry
// each request is handled in steps: the bucket row is first read from the table
// memory, then all ways are compared, the row is written back and the result
// register is loaded; the read-modify-write of one bucket row means a new
// request is not taken while the previous one is still in the compare step,
// and the response is valid once the result register is loaded
// the result sits in an output register, so the next request is accepted
// while a response still waits; if rsp_ch stalls with a response pending, the
// following request holds in the compare step until the register frees up
// after reset the table is cleared one bucket row per cycle, over all buckets;
// req_ch.ready stays low during that pass
// all entries are invalid after reset
module five_tuple_flow_table_core import fttbl_pkg::*; #(
   parameter int unsigned BUCKET_BITS = 4,
   parameter int unsigned WAYS        = 4
) (
   input  logic         clock,
   input  logic         reset,
   fttbl_req_if.sink    req_ch,
   fttbl_rsp_if.source  rsp_ch
);

   localparam int unsigned BUCKETS = 1 << BUCKET_BITS;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_LOOK  = 3'b100
   } state_type;

   typedef entry_type [WAYS-1:0] row_type;

   state_type              state_ff, state_in;
   logic [BUCKET_BITS-1:0] clr_cnt_ff, clr_cnt_in;

   logic [FUNC_W-1:0]      func_ff;
   key_type                key_ff;
   attr_type               new_attr_ff;
   logic [BUCKET_BITS-1:0] bucket_ff;

   row_type                mem [BUCKETS];
   row_type                rd_row_ff;
   logic [BUCKET_BITS-1:0] rd_addr;
   logic                   mem_we;
   logic [BUCKET_BITS-1:0] mem_waddr;
   row_type                mem_wdata;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff;
   attr_type               rsp_attr_ff;

   key_type                req_key;
   logic [ADDR_W-1:0]      req_hash;
   logic                   req_fire;
   logic                   look_done;

   logic [WAYS-1:0]        hit_oh;
   logic [WAYS-1:0]        free_oh;
   logic                   hit_any;
   logic                   free_any;
   attr_type               hit_attr;

   logic [STATUS_W-1:0]    res_status;
   attr_type               res_attr;
   logic                   res_write;
   row_type                mod_row;

   assign req_key.source_address      = req_ch.source_address;
   assign req_key.destination_address = req_ch.destination_address;
   assign req_key.source_port         = req_ch.source_port;
   assign req_key.destination_port    = req_ch.destination_port;
   assign req_key.protocol_number     = req_ch.protocol_number;
   assign req_hash                    = key_hash(req_key);

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign look_done    = (state_ff == ST_LOOK) && (!rsp_valid_ff || rsp_ch.ready);

   assign rd_addr = (state_ff == ST_IDLE) ? req_hash[BUCKET_BITS-1:0] : bucket_ff;

   // way compare and priority select
   always_comb begin
      hit_oh   = '0;
      free_oh  = '0;
      hit_any  = 1'b0;
      free_any = 1'b0;
      hit_attr = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (rd_row_ff[w].valid) begin
            if (!hit_any && rd_row_ff[w].key == key_ff) begin
               hit_oh[w] = 1'b1;
               hit_any   = 1'b1;
               hit_attr  = rd_row_ff[w].attr;
            end
         end else if (!free_any) begin
            free_oh[w] = 1'b1;
            free_any   = 1'b1;
         end
      end
   end

   always_comb begin
      res_status = STAT_NOT_FOUND;
      res_attr   = '0;
      res_write  = 1'b0;
      mod_row    = rd_row_ff;
      case (func_ff)
         FUNC_CREATE: begin
            if (hit_any) begin
               res_status = STAT_EXISTED;
               res_attr   = hit_attr;
            end else if (!free_any) begin
               res_status = STAT_FULL;
            end else begin
               res_status = STAT_CREATED;
               res_attr   = new_attr_ff;
               res_write  = 1'b1;
               for (int w = 0; w < WAYS; w++) begin
                  if (free_oh[w]) begin
                     mod_row[w].valid = 1'b1;
                     mod_row[w].key   = key_ff;
                     mod_row[w].attr  = new_attr_ff;
                  end
               end
            end
         end
         FUNC_DELETE: begin
            if (hit_any) begin
               res_status = STAT_FOUND;
               res_attr   = hit_attr;
               res_write  = 1'b1;
               for (int w = 0; w < WAYS; w++) begin
                  if (hit_oh[w]) begin
                     mod_row[w].valid = 1'b0;
                  end
               end
            end
         end
         default: begin
            if (hit_any) begin
               res_status = STAT_FOUND;
               res_attr   = hit_attr;
            end
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      mem_we     = 1'b0;
      mem_waddr  = bucket_ff;
      mem_wdata  = mod_row;
      case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (&clr_cnt_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (look_done) begin
               mem_we   = res_write;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (look_done) begin
         rsp_valid_in = 1'b1;
      end
   end

   // table memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_row_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff               <= req_ch.func;
         key_ff                <= req_key;
         new_attr_ff.recording <= req_ch.new_recording;
         new_attr_ff.budget    <= req_ch.new_budget;
         new_attr_ff.owner     <= req_ch.new_owner;
         bucket_ff             <= req_hash[BUCKET_BITS-1:0];
      end
      if (look_done) begin
         rsp_status_ff <= res_status;
         rsp_attr_ff   <= res_attr;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = rsp_status_ff;
   assign rsp_ch.found_recording = rsp_attr_ff.recording;
   assign rsp_ch.found_budget    = rsp_attr_ff.budget;
   assign rsp_ch.found_owner     = rsp_attr_ff.owner;

endmodule
